// ===== sv/ipgp_pkg.sv =====
// shared types, constants and helper functions of the indexed pixel gray packer
package ipgp_pkg;

	localparam int MAX_ROW_PIXELS = 2048;
	localparam int PALETTE_DEPTH  = 256;

	// column counter holds 0 .. MAX_ROW_PIXELS, and must also compare against row_pixels
	localparam int COL_W = $clog2(MAX_ROW_PIXELS + 1);
	localparam int CW    = (COL_W > 12) ? COL_W : 12;
	localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	// linear gray ramp steps for 2 and 4 bit indices
	localparam int RAMP2 = 255 / 3;
	localparam int RAMP4 = 255 / 15;

	// decoupling queue between front and back
	localparam int QDEPTH = 2;
	localparam int QAW    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	// register file
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam logic [1:0] REG_DEPTH_MODE      = 2'd0;
	localparam logic [1:0] REG_ROW_PIXELS      = 2'd1;
	localparam logic [1:0] REG_PALETTE_PRESENT = 2'd2;

	localparam int REG_ROW_PIXELS_RESET = 1872;

	typedef enum logic [1:0] {
		MODE_1BPP = 2'd0,
		MODE_2BPP = 2'd1,
		MODE_4BPP = 2'd2,
		MODE_8BPP = 2'd3
	} mode_t;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_PIXEL = 1'b1
	} req_t;

	typedef struct packed {
		mode_t       depth_mode;
		logic [11:0] row_pixels;
		logic        palette_present;
	} cfg_t;

	// one classified pixel byte on its way to the back end
	typedef struct packed {
		mode_t      mode;
		logic       pp;
		logic       emit;
		logic       upd_pack;
		logic       clr_pack;
		logic [7:0] pix;
		logic [7:0] res2;
		logic [7:0] rd_a;
		logic [7:0] rd_b;
		logic       ok_a;
		logic       ok_b;
	} rec_t;

	function automatic logic in_range(input logic [7:0] idx);
		return {1'b0, idx} < 9'(PALETTE_DEPTH);
	endfunction

	function automatic logic [7:0] ramp(input logic [7:0] idx, input int step);
		logic [15:0] p;
		p = {8'd0, idx} * 16'(step);
		return p[7:0];
	endfunction

endpackage

// ===== sv/ipgp_if.sv =====
// valid/ready channel interfaces for pixel requests and gray results
interface ipgp_in_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] entry_index;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] pixel_byte;
	logic       row_end;

	modport source (output valid, req_type, entry_index, red, green, blue, pixel_byte,
		row_end, input ready);
	modport sink (input valid, req_type, entry_index, red, green, blue, pixel_byte,
		row_end, output ready);
endinterface

interface ipgp_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] gray_byte;

	modport source (output valid, gray_byte, input ready);
	modport sink (input valid, gray_byte, output ready);
endinterface

// ===== sv/ipgp_front.sv =====
// front end: accepts requests, loads the palette, tracks the row column and reads grays
module ipgp_front (
	input  logic            clk,
	input  logic            arst_n,
	ipgp_in_if.sink         in_ch,
	input  ipgp_pkg::cfg_t  cfg,
	output ipgp_pkg::rec_t  rec,
	output logic            rec_valid,
	input  logic            rec_ready
);
	import ipgp_pkg::*;

	logic [7:0]    pal_mem [0:PALETTE_DEPTH-1];
	logic [1:0]    sh_q [0:3];
	logic [CW-1:0] col_q;
	logic          v_s1;
	rec_t          rec_s1;
	logic [7:0]    rd_a_s1;
	logic [7:0]    rd_b_s1;
	rec_t          rec_d;

	logic          accept;
	logic          load_we;
	logic          pix_acc;
	logic [9:0]    gsum;
	logic [7:0]    gray_ld;
	logic [CW-1:0] len;
	logic [CW-1:0] rem;
	logic          in_row;
	logic [CW-1:0] adv;
	logic [CW:0]   sum;
	logic [CW-1:0] col_nxt;
	logic [7:0]    ra;
	logic [7:0]    rb;
	logic [1:0]    idx2 [0:3];
	logic [7:0]    rmp2 [0:3];
	logic [1:0]    g2 [0:3];

	assign in_ch.ready = !v_s1 || rec_ready;
	assign accept  = in_ch.valid && in_ch.ready;
	assign load_we = accept && (in_ch.req_type == REQ_LOAD) && in_range(in_ch.entry_index);
	assign pix_acc = accept && (in_ch.req_type == REQ_PIXEL);

	assign gsum = {2'b0, in_ch.red} + {1'b0, in_ch.green, 1'b0} + {2'b0, in_ch.blue} + 10'd2;
	assign gray_ld = gsum[9:2];

	assign len = (CW'(cfg.row_pixels) > CW'(MAX_ROW_PIXELS)) ? CW'(MAX_ROW_PIXELS)
		: CW'(cfg.row_pixels);
	assign in_row = col_q < len;
	assign rem = len - col_q;

	always_comb begin
		adv = '0;
		rec_d = '0;
		rec_d.mode = cfg.depth_mode;
		rec_d.pp = cfg.palette_present;
		rec_d.pix = in_ch.pixel_byte;
		rec_d.clr_pack = in_ch.row_end;
		case (cfg.depth_mode)
			MODE_1BPP: begin
				adv = CW'(8);
				rec_d.emit = 1'b1;
			end
			MODE_2BPP: begin
				if (in_row) begin
					adv = (rem < CW'(4)) ? rem : CW'(4);
					rec_d.emit = rem >= CW'(4);
				end
			end
			MODE_4BPP: begin
				if (in_row) begin
					adv = (rem < CW'(2)) ? rem : CW'(2);
					rec_d.emit = rem >= CW'(2);
				end
			end
			MODE_8BPP: begin
				if (in_row) begin
					adv = CW'(1);
					rec_d.upd_pack = 1'b1;
					rec_d.emit = col_q[0];
				end
			end
			default: begin
				adv = '0;
			end
		endcase

		// 2bpp grays: four low palette entries in flops, or the ramp
		for (int k = 0; k < 4; k++) begin
			idx2[k] = in_ch.pixel_byte[7-2*k -: 2];
			rmp2[k] = ramp({6'd0, idx2[k]}, RAMP2);
			if (cfg.palette_present) begin
				g2[k] = in_range({6'd0, idx2[k]}) ? sh_q[idx2[k]] : 2'd0;
			end else begin
				g2[k] = rmp2[k][7:6];
			end
		end
		rec_d.res2 = {g2[0], g2[1], g2[2], g2[3]};

		if (cfg.depth_mode == MODE_8BPP) begin
			ra = in_ch.pixel_byte;
		end else begin
			ra = {4'd0, in_ch.pixel_byte[7:4]};
		end
		rb = {4'd0, in_ch.pixel_byte[3:0]};
		rec_d.ok_a = in_range(ra);
		rec_d.ok_b = in_range(rb);
	end

	assign sum = {1'b0, col_q} + {1'b0, adv};
	assign col_nxt = (sum > (CW+1)'(MAX_ROW_PIXELS)) ? CW'(MAX_ROW_PIXELS) : sum[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				v_s1 <= pix_acc;
			end
			if (pix_acc) begin
				col_q <= in_ch.row_end ? '0 : col_nxt;
			end
		end
	end

	// palette memory with two registered read ports, read when a pixel byte is taken
	always_ff @(posedge clk) begin
		if (load_we) begin
			pal_mem[in_ch.entry_index[PAL_AW-1:0]] <= gray_ld;
			if (in_ch.entry_index < 8'd4) begin
				sh_q[in_ch.entry_index[1:0]] <= gray_ld[7:6];
			end
		end
		if (pix_acc) begin
			rec_s1 <= rec_d;
			rd_a_s1 <= pal_mem[ra[PAL_AW-1:0]];
			rd_b_s1 <= pal_mem[rb[PAL_AW-1:0]];
		end
	end

	always_comb begin
		rec = rec_s1;
		rec.rd_a = rd_a_s1;
		rec.rd_b = rd_b_s1;
	end

	assign rec_valid = v_s1;

endmodule

// ===== sv/ipgp_queue.sv =====
// short fifo that decouples the front end from the back end
module ipgp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  ipgp_pkg::rec_t push_rec,
	input  logic           push_valid,
	output logic           push_ready,
	output ipgp_pkg::rec_t pop_rec,
	output logic           pop_valid,
	input  logic           pop_ready
);
	import ipgp_pkg::*;

	rec_t           slot_q [0:QDEPTH-1];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;
	logic           push;
	logic           pop;

	assign push_ready = count_q < (QAW+1)'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign push = push_valid && push_ready;
	assign pop  = pop_valid && pop_ready;
	assign pop_rec = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_rec;
		end
	end

endmodule

// ===== sv/ipgp_back.sv =====
// back end: forms the packed gray byte, keeps the 8bpp nibble pair, holds the output
module ipgp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ipgp_pkg::rec_t rec,
	input  logic           rec_valid,
	output logic           rec_ready,
	ipgp_out_if.source     out_ch
);
	import ipgp_pkg::*;

	logic [7:0] acc_q;
	logic       out_valid_q;
	logic [7:0] gray_q;
	logic       pop;
	logic [7:0] g_hi;
	logic [7:0] g_lo;
	logic [7:0] g_8;
	logic [7:0] acc_nxt;
	logic [7:0] res;

	assign rec_ready = !out_valid_q || out_ch.ready;
	assign pop = rec_valid && rec_ready;

	always_comb begin
		if (rec.pp) begin
			g_hi = rec.ok_a ? rec.rd_a : 8'd0;
			g_lo = rec.ok_b ? rec.rd_b : 8'd0;
			g_8  = rec.ok_a ? rec.rd_a : 8'd0;
		end else begin
			g_hi = ramp({4'd0, rec.pix[7:4]}, RAMP4);
			g_lo = ramp({4'd0, rec.pix[3:0]}, RAMP4);
			g_8  = rec.pix;
		end
		acc_nxt = {acc_q[3:0], g_8[7:4]};
		case (rec.mode)
			MODE_1BPP: res = rec.pix;
			MODE_2BPP: res = rec.res2;
			MODE_4BPP: res = {g_hi[7:4], g_lo[7:4]};
			MODE_8BPP: res = acc_nxt;
			default:   res = rec.pix;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rec_ready) begin
				out_valid_q <= rec_valid && rec.emit;
			end
			// row end clears after the byte has been packed
			if (pop) begin
				if (rec.clr_pack) begin
					acc_q <= '0;
				end else if (rec.upd_pack) begin
					acc_q <= acc_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && rec.emit) begin
			gray_q <= res;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.gray_byte = gray_q;

endmodule

// ===== sv/indexed_pixel_gray_packer_unit.sv =====
// a result passes the front register, the queue and the output register after its pixel byte is accepted
// throughput: one request per cycle while the queue has room, set by the two-port palette memory read per pixel byte
// a palette load is taken and gives no result
// the output register and a two-entry queue let input continue while a result waits
// reset (arst_n low, asynchronous) clears registers to defaults, column, nibble pair, queue
// the palette has no clearing pass and holds nothing defined until loaded
module indexed_pixel_gray_packer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	ipgp_in_if.sink                     in_ch,
	ipgp_out_if.source                  out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ipgp_pkg::APB_AW-1:0] paddr,
	input  logic [ipgp_pkg::APB_DW-1:0] pwdata,
	output logic [ipgp_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);
	import ipgp_pkg::*;

	cfg_t       cfg_q;
	logic       cfg_we;
	logic [1:0] reg_idx;
	rec_t       f_rec;
	logic       f_valid;
	logic       f_ready;
	rec_t       q_rec;
	logic       q_valid;
	logic       q_ready;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_mode <= MODE_1BPP;
			cfg_q.row_pixels <= 12'(REG_ROW_PIXELS_RESET);
			cfg_q.palette_present <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx)
				REG_DEPTH_MODE:      cfg_q.depth_mode <= mode_t'(pwdata[1:0]);
				REG_ROW_PIXELS:      cfg_q.row_pixels <= pwdata[11:0];
				REG_PALETTE_PRESENT: cfg_q.palette_present <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_DEPTH_MODE:      prdata = {30'd0, cfg_q.depth_mode};
			REG_ROW_PIXELS:      prdata = {20'd0, cfg_q.row_pixels};
			REG_PALETTE_PRESENT: prdata = {31'd0, cfg_q.palette_present};
			default:             prdata = '0;
		endcase
	end

	ipgp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.cfg       (cfg_q),
		.rec       (f_rec),
		.rec_valid (f_valid),
		.rec_ready (f_ready)
	);

	ipgp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_rec   (f_rec),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_rec    (q_rec),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	ipgp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec       (q_rec),
		.rec_valid (q_valid),
		.rec_ready (q_ready),
		.out_ch    (out_ch)
	);

endmodule

// ===== sv/ipgp_checker.sv =====
// port-level checks of the gray packer and their bind to the top level
module ipgp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] gray_byte
);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(gray_byte))
		else $error("gray result changed while stalled");

	// checks that input only backs up when a result is waiting at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

	// with no transaction accepted and the output empty over the sampled past, nothing is left inside
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !$past(out_valid) && !$past(out_valid, 2) && !$past(out_valid, 3)
		&& !$past(in_acc) && !$past(in_acc, 2) && !$past(in_acc, 3)
		|=> !out_valid)
		else $error("result appeared without a transaction");

endmodule

bind indexed_pixel_gray_packer_unit ipgp_checker u_ipgp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.gray_byte (out_ch.gray_byte)
);
